// File: rtl/core/rd_pkg.sv
// Shared types and codes for the record deque.
// Used by every module of the block but rd_ram; depends on nothing else.
package rd_pkg;

	localparam int ACT_W    = 3;
	localparam int POS_W    = 10;
	localparam int LETTER_W = 8;
	localparam int COUNT_W  = 17;
	localparam int STAT_W   = 2;
	localparam int OCC_W    = 11;

	// Action codes carried by each input item.
	localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd1;
	localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_READ       = 3'd4;

	// Status codes returned with each result.
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic [LETTER_W-1:0] letter;
		logic [COUNT_W-1:0]  count;
		logic                flag;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	// What the control stage hands on for one accepted item.
	typedef struct packed {
		logic              use_data;
		logic [STAT_W-1:0] status;
		logic [OCC_W-1:0]  occupancy;
	} info_t;

endpackage

// File: rtl/core/record_deque.sv
// Top level of the record deque: control, record store and result path.
// Depends on rd_pkg, rd_ctrl, rd_ram and rd_out.

// The deque takes one item per cycle unless the result path stalls, and returns
// one result per item, in order, through stage one and the output register.
// Records live in a single RAM of CAPACITY entries with one write and
// one registered read port; a push writes it in the accept cycle and a pop
// or read issues its read then, so that port sets the figure of one item a
// cycle. Front pointer and fill count are flip-flops that reset clears; the
// store itself needs no clearing pass, as only pushed entries are ever read.
// Occupancy is reported in 11 bits.
module record_deque #(
	parameter int CAPACITY = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [rd_pkg::ACT_W-1:0]     action,
	input  logic [rd_pkg::POS_W-1:0]     position,
	input  logic [rd_pkg::LETTER_W-1:0]  in_letter,
	input  logic [rd_pkg::COUNT_W-1:0]   in_count,
	input  logic                         in_flag,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rd_pkg::LETTER_W-1:0]  out_letter,
	output logic [rd_pkg::COUNT_W-1:0]   out_count,
	output logic                         out_flag,
	output logic [rd_pkg::STAT_W-1:0]    status,
	output logic [rd_pkg::OCC_W-1:0]     occupancy
);
	import rd_pkg::*;

	localparam int AW = $clog2(CAPACITY);

	logic          accept;
	rec_t          rec_in;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_addr;
	logic [REC_W-1:0] rdata;
	info_t         info;

	assign accept        = in_valid & in_ready;
	assign rec_in.letter = in_letter;
	assign rec_in.count  = in_count;
	assign rec_in.flag   = in_flag;

	rd_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.action   (action),
		.position (position),
		.mem_we   (mem_we),
		.mem_re   (mem_re),
		.mem_addr (mem_addr),
		.info     (info)
	);

	rd_ram #(.WIDTH(REC_W), .DEPTH(CAPACITY)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_addr),
		.wdata (rec_in),
		.re    (mem_re),
		.raddr (mem_addr),
		.rdata (rdata)
	);

	rd_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.info       (info),
		.rdata      (rdata),
		.in_ready   (in_ready),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.out_letter (out_letter),
		.out_count  (out_count),
		.out_flag   (out_flag),
		.status     (status),
		.occupancy  (occupancy)
	);

endmodule

// File: rtl/core/rd_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Stand-alone; no package needed.
module rd_ram #(
	parameter int WIDTH = 26,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read; the read data holds until the next read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/rd_ctrl.sv
// Ring pointer and fill count of the deque, decoding of each action and
// the record store access it needs. Uses rd_pkg.
module rd_ctrl #(
	parameter int CAPACITY = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [rd_pkg::ACT_W-1:0]    action,
	input  logic [rd_pkg::POS_W-1:0]    position,
	output logic                        mem_we,
	output logic                        mem_re,
	output logic [$clog2(CAPACITY)-1:0] mem_addr,
	output rd_pkg::info_t               info
);
	import rd_pkg::*;

	localparam int AW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	logic [AW-1:0]   front_q, front_d;
	logic [CW-1:0]   count_q, count_d;
	logic [AW-1:0]   front_inc, front_dec, offset, slot;
	logic [AW:0]     slot_sum;
	logic            full, empty, in_range, we, re;
	logic [STAT_W-1:0] status;

	assign full     = (count_q == CW'(CAPACITY));
	assign empty    = (count_q == '0);
	assign in_range = (CMPW'(position) < CMPW'(count_q));

	// Neighbouring ring slots of the front, wrapping at the capacity.
	assign front_inc = (front_q == AW'(CAPACITY - 1)) ? '0 : front_q + 1'b1;
	assign front_dec = (front_q == '0) ? AW'(CAPACITY - 1) : front_q - 1'b1;

	// Slot at an offset from the front; the sum stays below twice the capacity.
	assign slot_sum = {1'b0, front_q} + {1'b0, offset};
	assign slot     = (slot_sum >= (AW + 1)'(CAPACITY)) ?
	                  AW'(slot_sum - (AW + 1)'(CAPACITY)) : slot_sum[AW-1:0];

	// Action decode.
	always_comb begin
		front_d  = front_q;
		count_d  = count_q;
		offset   = AW'(count_q);
		mem_addr = slot;
		we       = 1'b0;
		re       = 1'b0;
		status   = ST_OK;
		unique case (action)
			ACT_PUSH_BACK: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					we      = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			ACT_PUSH_FRONT: begin
				mem_addr = front_dec;
				if (full) begin
					status = ST_FULL;
				end else begin
					we      = 1'b1;
					front_d = front_dec;
					count_d = count_q + 1'b1;
				end
			end
			ACT_POP_BACK: begin
				offset = AW'(count_q - 1'b1);
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					re      = 1'b1;
					count_d = count_q - 1'b1;
				end
			end
			ACT_POP_FRONT: begin
				mem_addr = front_q;
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					re      = 1'b1;
					front_d = front_inc;
					count_d = count_q - 1'b1;
				end
			end
			ACT_READ: begin
				offset = AW'(position);
				if (in_range) begin
					re = 1'b1;
				end else begin
					status = ST_RANGE;
				end
			end
			default: begin
			end
		endcase
	end

	assign mem_we = accept & we;
	assign mem_re = accept & re;

	assign info.use_data  = re;
	assign info.status    = status;
	assign info.occupancy = OCC_W'(count_d);

	// Pointer and count advance on each accepted transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_d;
			count_q <= count_d;
		end
	end

endmodule

// File: rtl/core/rd_out.sv
// Result path: a stage that meets the store's read data, then the output
// register, with the input handshake derived from both. Uses rd_pkg.
module rd_out (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  rd_pkg::info_t                 info,
	input  logic [rd_pkg::REC_W-1:0]      rdata,
	output logic                          in_ready,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [rd_pkg::LETTER_W-1:0]   out_letter,
	output logic [rd_pkg::COUNT_W-1:0]    out_count,
	output logic                          out_flag,
	output logic [rd_pkg::STAT_W-1:0]     status,
	output logic [rd_pkg::OCC_W-1:0]      occupancy
);
	import rd_pkg::*;

	logic  valid_s1;
	info_t info_s1;
	logic  advance;
	rec_t  rec_rd;
	logic  valid_q;
	rec_t  rec_q;
	logic [STAT_W-1:0] status_q;
	logic [OCC_W-1:0]  occ_q;

	// The stage moves on when the output register is free or being emptied.
	assign advance  = valid_s1 & (~valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;
	assign rec_rd   = rec_t'(rdata);

	// Stage one: item info while the store read completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info;
		end
	end

	// Output register; records are zero unless a pop or read succeeded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rec_q    <= info_s1.use_data ? rec_rd : '0;
			status_q <= info_s1.status;
			occ_q    <= info_s1.occupancy;
		end
	end

	assign out_valid  = valid_q;
	assign out_letter = rec_q.letter;
	assign out_count  = rec_q.count;
	assign out_flag   = rec_q.flag;
	assign status     = status_q;
	assign occupancy  = occ_q;

endmodule

// File: rtl/core/rd_checker.sv
// Port-level checks for the record deque, bound to the top level.
// Depends on rd_pkg and record_deque.
module rd_checker #(
	parameter int CAPACITY = 1024
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [rd_pkg::LETTER_W-1:0]  out_letter,
	input logic [rd_pkg::COUNT_W-1:0]   out_count,
	input logic                         out_flag,
	input logic [rd_pkg::STAT_W-1:0]    status,
	input logic [rd_pkg::OCC_W-1:0]     occupancy
);
	import rd_pkg::*;

	// A stalled result stays offered and unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_letter)
		&& $stable(out_count) && $stable(out_flag) && $stable(status)
		&& $stable(occupancy))
	else $error("stalled result changed");

	// A dropped push is only reported when the deque is full.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> occupancy == OCC_W'(CAPACITY))
	else $error("full status with spare room");

	// A failed pop is only reported when the deque is empty.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> occupancy == '0)
	else $error("empty status with records stored");

	// Any error result carries a zero record.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |->
		out_letter == '0 && out_count == '0 && out_flag == 1'b0)
	else $error("error result carries a record");

endmodule

bind record_deque rd_checker #(.CAPACITY(CAPACITY)) u_rd_checker (.*);

// File: tb/sv/record_deque_checker.sv
// Checker for the record deque: watches both channels, predicts each result.
// Depends on rd_pkg for the record layout, action codes and status codes.
module record_deque_checker #(
	parameter int CAPACITY = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [rd_pkg::ACT_W-1:0]     action,
	input  logic [rd_pkg::POS_W-1:0]     position,
	input  logic [rd_pkg::LETTER_W-1:0]  in_letter,
	input  logic [rd_pkg::COUNT_W-1:0]   in_count,
	input  logic                         in_flag,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [rd_pkg::LETTER_W-1:0]  out_letter,
	input  logic [rd_pkg::COUNT_W-1:0]   out_count,
	input  logic                         out_flag,
	input  logic [rd_pkg::STAT_W-1:0]    status,
	input  logic [rd_pkg::OCC_W-1:0]     occupancy,
	output int                           fails,
	output int                           pending,
	output int                           checked,
	output int                           full_refusals,
	output int                           empty_pops,
	output int                           range_misses
);
	import rd_pkg::*;

	typedef struct packed {
		rec_t              rec;
		logic [STAT_W-1:0] status;
		logic [OCC_W-1:0]  occupancy;
	} deque_result_t;

	// Shadow of the deque: ring of records, slot of the front record, fill.
	rec_t          shadow_store [CAPACITY];
	int            head_slot;
	int            fill;
	deque_result_t due_results [$];
	int            fail_count;
	int            seen;
	int            n_full;
	int            n_empty;
	int            n_range;

	// Applies one accepted item to the shadow and returns the result it owes.
	function automatic deque_result_t predict_deque_result(
		logic [ACT_W-1:0] act, logic [POS_W-1:0] pos, rec_t rec
	);
		deque_result_t r;
		r = '0;
		case (act)
			ACT_PUSH_BACK: begin
				if (fill >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					shadow_store[(head_slot + fill) % CAPACITY] = rec;
					fill++;
				end
			end
			ACT_PUSH_FRONT: begin
				if (fill >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					head_slot = (head_slot + CAPACITY - 1) % CAPACITY;
					shadow_store[head_slot] = rec;
					fill++;
				end
			end
			ACT_POP_BACK: begin
				if (fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					fill--;
					r.rec = shadow_store[(head_slot + fill) % CAPACITY];
				end
			end
			ACT_POP_FRONT: begin
				if (fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.rec = shadow_store[head_slot];
					head_slot = (head_slot + 1) % CAPACITY;
					fill--;
				end
			end
			ACT_READ: begin
				if (int'(pos) >= fill) begin
					r.status = ST_RANGE;
				end else begin
					r.rec = shadow_store[(head_slot + int'(pos)) % CAPACITY];
				end
			end
			default: begin
				// Spare action codes leave everything as it is.
			end
		endcase
		r.occupancy = fill[OCC_W-1:0];
		return r;
	endfunction

	// Reports one field that differs from its expectation.
	function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			fail_count++;
		end
	endfunction

	// Result transfers are matched first, since an item accepted at this edge
	// cannot have its result on the output at the same edge.
	always @(posedge clk or negedge arst_n) begin
		deque_result_t want;
		if (!arst_n) begin
			head_slot  = 0;
			fill       = 0;
			due_results.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: result transfer with nothing expected, actual status %0d",
						$time, status);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					seen++;
					case (want.status)
						ST_FULL:  n_full++;
						ST_EMPTY: n_empty++;
						ST_RANGE: n_range++;
						default: ;
					endcase
					compare_field("out_letter", 32'(want.rec.letter), 32'(out_letter));
					compare_field("out_count", 32'(want.rec.count), 32'(out_count));
					compare_field("out_flag", 32'(want.rec.flag), 32'(out_flag));
					compare_field("status", 32'(want.status), 32'(status));
					compare_field("occupancy", 32'(want.occupancy), 32'(occupancy));
				end
			end
			if (in_valid && in_ready) begin
				due_results.push_back(predict_deque_result(action, position,
					'{letter: in_letter, count: in_count, flag: in_flag}));
			end
		end
		fails         <= fail_count;
		pending       <= due_results.size();
		checked       <= seen;
		full_refusals <= n_full;
		empty_pops    <= n_empty;
		range_misses  <= n_range;
	end

	initial begin
		fail_count = 0;
		seen       = 0;
		n_full     = 0;
		n_empty    = 0;
		n_range    = 0;
		head_slot  = 0;
		fill       = 0;
	end

endmodule

// File: tb/sv/tb.sv
// Testbench top for the record deque: clock, reset, stimulus and verdict.
// Depends on rd_pkg, record_deque and record_deque_checker.
module tb;
	import rd_pkg::*;

	localparam int                 CAPACITY       = 1024;
	localparam int                 CYCLE_LIMIT    = 600000;
	localparam logic [ACT_W-1:0]   ACT_SPARE_LO   = 3'd5;
	localparam logic [ACT_W-1:0]   ACT_SPARE_MID  = 3'd6;
	localparam logic [ACT_W-1:0]   ACT_SPARE_HI   = 3'd7;
	localparam logic [COUNT_W-1:0] COUNT_MAX      = 17'd100000;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_ready;
	logic [ACT_W-1:0]    action     = '0;
	logic [POS_W-1:0]    position   = '0;
	logic [LETTER_W-1:0] in_letter  = '0;
	logic [COUNT_W-1:0]  in_count   = '0;
	logic                in_flag    = 1'b0;
	logic                out_valid;
	logic                out_ready  = 1'b0;
	logic [LETTER_W-1:0] out_letter;
	logic [COUNT_W-1:0]  out_count;
	logic                out_flag;
	logic [STAT_W-1:0]   status;
	logic [OCC_W-1:0]    occupancy;

	int   fails;
	int   pending;
	int   checked;
	int   full_refusals;
	int   empty_pops;
	int   range_misses;
	int   cycles       = 0;
	int   items_sent   = 0;
	int   fill_est     = 0;
	int   stall_left   = 0;
	logic calm         = 1'b0;

	always #5 clk = ~clk;

	record_deque #(.CAPACITY(CAPACITY)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .position(position),
		.in_letter(in_letter), .in_count(in_count), .in_flag(in_flag),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_letter(out_letter), .out_count(out_count), .out_flag(out_flag),
		.status(status), .occupancy(occupancy)
	);

	record_deque_checker #(.CAPACITY(CAPACITY)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .position(position),
		.in_letter(in_letter), .in_count(in_count), .in_flag(in_flag),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_letter(out_letter), .out_count(out_count), .out_flag(out_flag),
		.status(status), .occupancy(occupancy),
		.fails(fails), .pending(pending), .checked(checked),
		.full_refusals(full_refusals), .empty_pops(empty_pops),
		.range_misses(range_misses)
	);

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
			$display("** record_deque: FAILED **");
			$finish;
		end
	end

	// Result side back-pressure: mostly ready, short stalls, now and then a long one.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (calm || $urandom_range(0, 99) < 70) begin
			out_ready <= 1'b1;
		end else begin
			out_ready  <= 1'b0;
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) - 1
				: $urandom_range(1, 3) - 1;
		end
	end

	// Idle cycles ahead of the next input transfer.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 75)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// Presents one item, holds it until the transfer, and tracks the fill.
	task automatic issue_op(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
		logic [LETTER_W-1:0] letter, logic [COUNT_W-1:0] cnt, logic flg);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		action    <= act;
		position  <= pos;
		in_letter <= letter;
		in_count  <= cnt;
		in_flag   <= flg;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
		if (items_sent % 150 == 0)
			calm <= ($urandom_range(0, 3) == 0);
		case (act)
			ACT_PUSH_BACK, ACT_PUSH_FRONT: if (fill_est < CAPACITY) fill_est++;
			ACT_POP_BACK, ACT_POP_FRONT:   if (fill_est > 0) fill_est--;
			default: ;
		endcase
	endtask

	// Drops valid and waits until every outstanding result has been checked.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// One random item; weights steer the fill towards empty or full.
	task automatic issue_random(int push_pct, int pop_pct);
		int               r;
		int               pr;
		logic [ACT_W-1:0] act;
		logic [POS_W-1:0] pos;
		logic [COUNT_W-1:0] cnt;
		r = $urandom_range(0, 99);
		if (r < push_pct)
			act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
		else if (r < push_pct + pop_pct)
			act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
		else if (r < 97)
			act = ACT_READ;
		else
			act = ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
		// Reads mostly land inside the fill, some on its edge, some anywhere.
		pr = $urandom_range(0, 99);
		if (act == ACT_READ && pr < 60 && fill_est > 0)
			pos = POS_W'($urandom_range(0, fill_est - 1));
		else if (act == ACT_READ && pr < 80)
			pos = (fill_est > 1023) ? 10'd1023 : POS_W'(fill_est);
		else
			pos = POS_W'($urandom_range(0, 1023));
		case ($urandom_range(0, 19))
			0:       cnt = '0;
			1:       cnt = COUNT_MAX;
			default: cnt = COUNT_W'($urandom_range(0, COUNT_MAX));
		endcase
		issue_op(act, pos, LETTER_W'($urandom_range(0, 255)), cnt,
			1'($urandom_range(0, 1)));
	endtask

	initial begin
		int guard;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty cases, spare codes, extreme records, both ends.
		issue_op(ACT_POP_BACK, 10'd0, 8'd0, '0, 1'b0);
		issue_op(ACT_POP_FRONT, 10'd0, 8'd0, '0, 1'b0);
		issue_op(ACT_READ, 10'd0, 8'd0, '0, 1'b0);
		issue_op(ACT_READ, 10'd1023, 8'd0, '0, 1'b0);
		issue_op(ACT_SPARE_LO, 10'd5, 8'd255, COUNT_MAX, 1'b1);
		issue_op(ACT_SPARE_MID, 10'd6, 8'd255, COUNT_MAX, 1'b1);
		issue_op(ACT_SPARE_HI, 10'd7, 8'd255, COUNT_MAX, 1'b1);
		issue_op(ACT_PUSH_BACK, 10'd0, 8'd255, COUNT_MAX, 1'b1);
		issue_op(ACT_PUSH_FRONT, 10'd0, 8'd0, '0, 1'b0);
		issue_op(ACT_PUSH_BACK, 10'd0, 8'hAA, 17'h0AAAA, 1'b0);
		issue_op(ACT_PUSH_FRONT, 10'd0, 8'h55, 17'h15555, 1'b1);
		issue_op(ACT_READ, 10'd0, 8'd0, '0, 1'b0);
		issue_op(ACT_READ, 10'd3, 8'd0, '0, 1'b0);
		issue_op(ACT_READ, 10'd4, 8'd0, '0, 1'b0);
		issue_op(ACT_READ, 10'd1023, 8'd0, '0, 1'b0);
		issue_op(ACT_POP_BACK, 10'd0, 8'd0, '0, 1'b0);
		issue_op(ACT_POP_FRONT, 10'd0, 8'd0, '0, 1'b0);
		issue_op(ACT_READ, 10'd0, 8'd0, '0, 1'b0);
		issue_op(ACT_READ, 10'd1, 8'd0, '0, 1'b0);
		issue_op(ACT_POP_FRONT, 10'd0, 8'd0, '0, 1'b0);
		issue_op(ACT_POP_FRONT, 10'd0, 8'd0, '0, 1'b0);
		issue_op(ACT_POP_BACK, 10'd0, 8'd0, '0, 1'b0);
		drain_results();

		// Mixed traffic around a near-empty deque, wrapping the ring both ways.
		repeat (250) issue_random(45, 35);

		// Fill to capacity with mostly pushes.
		guard = 0;
		while (fill_est < CAPACITY && guard < 3000) begin
			issue_random(93, 3);
			guard++;
		end
		drain_results();

		// Traffic at and just below full: refused pushes, deep reads.
		repeat (80) issue_random(60, 20);

		// Let everything come out, then allow for the pipeline.
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("record_deque: %0d items sent, %0d results checked", items_sent, checked);
		$display("record_deque: %0d refused pushes, %0d empty pops, %0d reads out of range",
			full_refusals, empty_pops, range_misses);
		if (fails == 0 && pending == 0) begin
			$display("** record_deque: PASSED **");
		end else begin
			$display("** record_deque: FAILED **");
		end
		$finish;
	end

endmodule
